>>> rtl/trc_pkg.sv
// Package for the ticket replay cache: sizes, status codes and the stored entry type.
// Used by the interfaces, the hour divider, the top level and the checker.
// No dependencies.
package trc_pkg;

  localparam int CACHE_ENTRIES = 256;
  localparam int ADDR_W = $clog2(CACHE_ENTRIES);
  localparam int FILL_W = $clog2(CACHE_ENTRIES + 1);

  localparam int KEY_W = 64;
  localparam int LEN_W = 8;
  localparam int TIME_W = 32;
  localparam int HOUR_W = 21;
  localparam int WIN_W = 17;
  localparam int STATUS_W = 2;

  localparam logic [LEN_W-1:0] MIN_TICKET_LEN = LEN_W'(129);
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(7200);

  localparam int SECONDS_PER_HOUR = 3600;

  // Seconds to hours: 3600 is 16 * 225, so drop four bits and multiply by
  // ceil(2^36 / 225), which is exact for every 28-bit value.
  localparam int HOUR_PRE_SHIFT = 4;
  localparam int HOUR_X_W = TIME_W - HOUR_PRE_SHIFT;
  localparam int HOUR_RECIP_W = 29;
  localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP = HOUR_RECIP_W'(305419897);
  localparam int HOUR_RECIP_SHIFT = 36;
  localparam int HOUR_PROD_W = HOUR_X_W + HOUR_RECIP_W;

  localparam logic [STATUS_W-1:0] STATUS_FRESH = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REPLAY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key_word3;
    logic [KEY_W-1:0] key_word2;
    logic [KEY_W-1:0] key_word1;
    logic [KEY_W-1:0] key_word0;
    logic [HOUR_W-1:0] hour;
    logic [TIME_W-1:0] seconds;
  } trc_entry_t;

  localparam int ENTRY_W = $bits(trc_entry_t);

endpackage

>>> rtl/trc_ifs.sv
// Channel interfaces of the ticket replay cache: check input, result output, window write.
// Depends on trc_pkg.
interface trc_check_if import trc_pkg::*; ();
  logic valid;
  logic ready;
  logic [KEY_W-1:0] key_word0;
  logic [KEY_W-1:0] key_word1;
  logic [KEY_W-1:0] key_word2;
  logic [KEY_W-1:0] key_word3;
  logic [LEN_W-1:0] ticket_length;
  logic [TIME_W-1:0] now_seconds;

  modport source (output valid, output key_word0, output key_word1, output key_word2,
                  output key_word3, output ticket_length, output now_seconds, input ready);
  modport sink (input valid, input key_word0, input key_word1, input key_word2,
                input key_word3, input ticket_length, input now_seconds, output ready);
endinterface

interface trc_result_if import trc_pkg::*; ();
  logic valid;
  logic ready;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output status, input ready);
  modport sink (input valid, input status, output ready);
endinterface

interface trc_cfg_if import trc_pkg::*; ();
  logic valid;
  logic ready;
  logic [WIN_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/trc_entry_ram.sv
// Single-port-write, single-port-read synchronous RAM holding the cache entries.
// Read data is registered. Depends on nothing.
module trc_entry_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/trc_hour_div.sv
// Seconds to hours by a shift and a reciprocal multiplication; done follows start via pend.
// Depends on trc_pkg.
module trc_hour_div import trc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend,
  output logic              done,
  output logic [HOUR_W-1:0] hour
);

  logic [HOUR_X_W-1:0]    x;
  logic                   pend;
  logic [HOUR_PROD_W-1:0] prod;

  assign prod = x * HOUR_RECIP;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      pend <= start;
      done <= pend;
      if (start) begin
        x <= dividend[TIME_W-1:HOUR_PRE_SHIFT];
      end
      if (pend) begin
        hour <= prod[HOUR_RECIP_SHIFT +: HOUR_W];
      end
    end
  end

endmodule

>>> rtl/ticket_replay_cache_unit.sv
// Ticket replay cache: checks a ticket key against a ring of recent keys in one RAM.
// A short ticket goes straight to its result; any other ticket first waits for the hour,
// then reads the RAM once per filled entry: a hit ends the scan at that entry, and a miss
// reads every filled entry and then writes the ticket at the write pointer.
// One ticket at a time; the next is taken the cycle after the result is registered.
// Synchronous active-high reset clears pointer, fill count and control; window is 7200.
module ticket_replay_cache_unit import trc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  trc_check_if.sink   check,
  trc_result_if.source result,
  trc_cfg_if.sink     cfg
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t              state;
  logic [WIN_W-1:0]    window;
  logic [ADDR_W-1:0]   write_pointer;
  logic [FILL_W-1:0]   fill_count;
  logic [FILL_W-1:0]   idx;
  logic                rd_pending;
  logic [STATUS_W-1:0] status_hold;
  trc_entry_t          cur;

  logic                div_start;
  logic                div_done;
  logic [HOUR_W-1:0]   div_hour;

  logic                rd_en;
  logic                wr_en;
  trc_entry_t          rd_entry;
  logic                hit;
  logic signed [TIME_W:0] age;

  trc_hour_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (check.now_seconds),
    .done     (div_done),
    .hour     (div_hour)
  );

  trc_entry_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (write_pointer),
    .wr_data (cur),
    .rd_en   (rd_en),
    .rd_addr (idx[ADDR_W-1:0]),
    .rd_data (rd_entry)
  );

  assign check.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign div_start = check.valid && check.ready && (check.ticket_length >= MIN_TICKET_LEN);

  assign age = $signed({1'b0, cur.seconds}) - $signed({1'b0, rd_entry.seconds});
  assign hit = rd_pending
            && (rd_entry.key_word0 == cur.key_word0)
            && (rd_entry.key_word1 == cur.key_word1)
            && (rd_entry.key_word2 == cur.key_word2)
            && (rd_entry.key_word3 == cur.key_word3)
            && (rd_entry.hour == cur.hour)
            && (age < $signed({{(TIME_W + 1 - WIN_W){1'b0}}, window}));

  // A miss is written only after the last read has returned, so reads and the write
  // of one ticket never touch the RAM in the same cycle.
  assign rd_en = (state == ST_SCAN) && !hit && (idx < fill_count);
  assign wr_en = (state == ST_SCAN) && !hit && (idx >= fill_count) && !rd_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      window <= WINDOW_RESET;
      write_pointer <= '0;
      fill_count <= '0;
      idx <= '0;
      rd_pending <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        window <= cfg.data;
      end
      if (result.valid && result.ready && state != ST_DONE) begin
        result.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (check.valid) begin
            cur.key_word0 <= check.key_word0;
            cur.key_word1 <= check.key_word1;
            cur.key_word2 <= check.key_word2;
            cur.key_word3 <= check.key_word3;
            cur.seconds <= check.now_seconds;
            if (check.ticket_length < MIN_TICKET_LEN) begin
              status_hold <= STATUS_SHORT;
              state <= ST_DONE;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            cur.hour <= div_hour;
            idx <= '0;
            rd_pending <= 1'b0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            rd_pending <= 1'b0;
            status_hold <= STATUS_REPLAY;
            state <= ST_DONE;
          end else if (rd_en) begin
            idx <= idx + 1'b1;
            rd_pending <= 1'b1;
          end else if (wr_en) begin
            write_pointer <= (write_pointer == ADDR_W'(CACHE_ENTRIES - 1)) ?
                             '0 : write_pointer + 1'b1;
            if (fill_count != FILL_W'(CACHE_ENTRIES)) begin
              fill_count <= fill_count + 1'b1;
            end
            status_hold <= STATUS_FRESH;
            state <= ST_DONE;
          end else begin
            rd_pending <= 1'b0;
          end
        end
        ST_DONE: begin
          if (!result.valid || result.ready) begin
            result.valid <= 1'b1;
            result.status <= status_hold;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/trc_checker.sv
// Port-level checker for the ticket replay cache and its bind to the top level.
// Depends on trc_pkg and ticket_replay_cache_unit.
module trc_checker import trc_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status
);

  a_reset_clears_result: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result valid after reset.");

  a_one_ticket_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("Check input ready right after a transaction.");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status == STATUS_FRESH || out_status == STATUS_REPLAY
                   || out_status == STATUS_SHORT))
    else $error("Undefined status code.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)))
    else $error("Stalled result changed.");

endmodule

bind ticket_replay_cache_unit trc_checker u_trc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (check.valid),
  .in_ready   (check.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_status (result.status)
);

>>> dv/ticket_replay_cache_unit_tb.sv
// Self-checking testbench for ticket_replay_cache_unit: directed and random ticket checks
// against a scoreboard that predicts replay, fresh and short verdicts, with window writes.
// Depends on trc_pkg, the trc_ifs interfaces and the ticket_replay_cache_unit RTL.
module ticket_replay_cache_unit_tb import trc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int POOL_KEYS = 16;

  typedef struct {
    logic [KEY_W-1:0] key_word0;
    logic [KEY_W-1:0] key_word1;
    logic [KEY_W-1:0] key_word2;
    logic [KEY_W-1:0] key_word3;
    logic [LEN_W-1:0] ticket_length;
    logic [TIME_W-1:0] now_seconds;
  } ticket_t;

  class replay_verdicts;
    logic [KEY_W-1:0] key_seen [CACHE_ENTRIES][4];
    logic [HOUR_W-1:0] hour_seen [CACHE_ENTRIES];
    logic [TIME_W-1:0] time_seen [CACHE_ENTRIES];
    int unsigned next_slot;
    int unsigned filled;
    logic [WIN_W-1:0] window;
    logic [STATUS_W-1:0] due [$];
    int unsigned bad;

    function new();
      next_slot = 0;
      filled = 0;
      window = WINDOW_RESET;
      bad = 0;
    endfunction

    function void set_window(logic [WIN_W-1:0] w);
      window = w;
    endfunction

    function void note_check(ticket_t t);
      logic [HOUR_W-1:0] hour;
      logic [STATUS_W-1:0] verdict;
      longint age;
      longint limit;
      int unsigned i;
      if (t.ticket_length < MIN_TICKET_LEN) begin
        due.push_back(STATUS_SHORT);
        return;
      end
      hour = HOUR_W'(t.now_seconds / TIME_W'(SECONDS_PER_HOUR));
      limit = window;
      verdict = STATUS_FRESH;
      for (i = 0; i < filled; i++) begin
        age = $signed({32'd0, t.now_seconds}) - $signed({32'd0, time_seen[i]});
        if (key_seen[i][0] == t.key_word0 && key_seen[i][1] == t.key_word1 &&
            key_seen[i][2] == t.key_word2 && key_seen[i][3] == t.key_word3 &&
            hour_seen[i] == hour && age < limit) begin
          verdict = STATUS_REPLAY;
          break;
        end
      end
      if (verdict == STATUS_FRESH) begin
        key_seen[next_slot][0] = t.key_word0;
        key_seen[next_slot][1] = t.key_word1;
        key_seen[next_slot][2] = t.key_word2;
        key_seen[next_slot][3] = t.key_word3;
        hour_seen[next_slot] = hour;
        time_seen[next_slot] = t.now_seconds;
        next_slot = (next_slot + 1) % CACHE_ENTRIES;
        if (filled < CACHE_ENTRIES) begin
          filled++;
        end
      end
      due.push_back(verdict);
    endfunction

    function void check_status(logic [STATUS_W-1:0] got);
      logic [STATUS_W-1:0] want;
      if (due.size() == 0) begin
        bad++;
        if (bad <= 10) begin
          $display("unexpected result transaction, status %0d", got);
        end
        return;
      end
      want = due.pop_front();
      if (got !== want) begin
        bad++;
        if (bad <= 10) begin
          $display("status mismatch: expected %0d, got %0d", want, got);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  trc_check_if chk ();
  trc_result_if res ();
  trc_cfg_if cfg_ch ();

  ticket_replay_cache_unit dut (
    .clk    (clk),
    .rst    (rst),
    .check  (chk),
    .result (res),
    .cfg    (cfg_ch)
  );

  replay_verdicts verdicts = new();

  logic [KEY_W-1:0] key_pool [POOL_KEYS][4];
  logic [TIME_W-1:0] clock_now;
  int burst_left;
  int cycles;
  int rx_mode;
  int rx_mode_left;
  int rx_stall_left;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      verdicts.check_status(res.status);
    end
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(50, 600);
      end
      rx_mode_left--;
      case (rx_mode)
        0: res.ready <= 1'b1;
        1: res.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (rx_stall_left > 0) begin
            rx_stall_left--;
            res.ready <= 1'b0;
          end else begin
            res.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
              rx_stall_left = $urandom_range(1, 40);
            end
          end
        end
      endcase
    end
  end

  function automatic logic [KEY_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic void refresh_key(int idx);
    for (int w = 0; w < 4; w++) begin
      key_pool[idx][w] = rand_word();
    end
  endfunction

  function automatic ticket_t pool_ticket(int idx, logic [LEN_W-1:0] len,
                                          logic [TIME_W-1:0] now);
    ticket_t t;
    t.key_word0 = key_pool[idx][0];
    t.key_word1 = key_pool[idx][1];
    t.key_word2 = key_pool[idx][2];
    t.key_word3 = key_pool[idx][3];
    t.ticket_length = len;
    t.now_seconds = now;
    return t;
  endfunction

  task automatic send_ticket(input ticket_t t);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 5))
        0, 1: gap = 0;
        2, 3, 4: gap = $urandom_range(1, 30);
        default: gap = $urandom_range(60, 350);
      endcase
      if (gap != 0) begin
        chk.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    chk.valid <= 1'b1;
    chk.key_word0 <= t.key_word0;
    chk.key_word1 <= t.key_word1;
    chk.key_word2 <= t.key_word2;
    chk.key_word3 <= t.key_word3;
    chk.ticket_length <= t.ticket_length;
    chk.now_seconds <= t.now_seconds;
    do @(posedge clk); while (!chk.ready);
    verdicts.note_check(t);
    burst_left--;
  endtask

  task automatic wait_drained();
    chk.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (verdicts.due.size() != 0);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] w);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    verdicts.set_window(w);
  endtask

  task automatic run_random(input int count);
    int pick;
    int idx;
    logic [LEN_W-1:0] len;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      idx = $urandom_range(0, POOL_KEYS - 1);
      len = LEN_W'($urandom_range(129, 255));
      if (pick < 8) begin
        send_ticket(pool_ticket(idx, LEN_W'($urandom_range(0, 128)), $urandom));
      end else if (pick < 13) begin
        refresh_key(idx);
        send_ticket(pool_ticket(idx, len, $urandom));
      end else begin
        case ($urandom_range(0, 9))
          0: clock_now = clock_now - TIME_W'($urandom_range(1, 200));
          1: clock_now = clock_now + TIME_W'($urandom_range(3000, 90000));
          2: ;
          default: clock_now = clock_now + TIME_W'($urandom_range(0, 120));
        endcase
        if ($urandom_range(0, 19) == 0) begin
          refresh_key(idx);
        end
        send_ticket(pool_ticket(idx, len, clock_now));
      end
    end
  endtask

  initial begin
    logic [WIN_W-1:0] windows [5];
    windows = '{WIN_W'(86400), WIN_W'(1), WIN_W'(65535), WIN_W'(600), WIN_W'(7200)};
    rst <= 1'b1;
    chk.valid <= 1'b0;
    chk.key_word0 <= '0;
    chk.key_word1 <= '0;
    chk.key_word2 <= '0;
    chk.key_word3 <= '0;
    chk.ticket_length <= '0;
    chk.now_seconds <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    burst_left = 0;
    for (int i = 0; i < POOL_KEYS; i++) begin
      refresh_key(i);
    end
    for (int w = 0; w < 4; w++) begin
      key_pool[3][w] = '1;
      key_pool[4][w] = '0;
      key_pool[5][w] = key_pool[0][w];
    end
    key_pool[5][3][0] = ~key_pool[5][3][0];
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_ticket(pool_ticket(0, 8'd129, 32'd0));
    send_ticket(pool_ticket(0, 8'd255, 32'd3599));
    send_ticket(pool_ticket(0, 8'd128, 32'd10));
    send_ticket(pool_ticket(0, 8'd0, 32'd10));
    send_ticket(pool_ticket(0, 8'd170, 32'd3600));
    send_ticket(pool_ticket(0, 8'd200, 32'd3650));
    send_ticket(pool_ticket(1, 8'd129, 32'd7300));
    send_ticket(pool_ticket(1, 8'd129, 32'd7250));
    send_ticket(pool_ticket(3, 8'd200, 32'hFFFF_FFFF));
    send_ticket(pool_ticket(3, 8'd200, 32'hFFFF_FFFF));
    send_ticket(pool_ticket(4, 8'd129, 32'd0));
    send_ticket(pool_ticket(4, 8'd129, 32'd5));
    send_ticket(pool_ticket(5, 8'd129, 32'd3650));
    wait_drained();
    write_window(WIN_W'(60));
    send_ticket(pool_ticket(2, 8'd129, 32'd100000));
    send_ticket(pool_ticket(2, 8'd129, 32'd100059));
    send_ticket(pool_ticket(2, 8'd129, 32'd100060));
    wait_drained();
    write_window(WIN_W'(0));
    send_ticket(pool_ticket(2, 8'd129, 32'd100030));
    send_ticket(pool_ticket(2, 8'd129, 32'd100060));
    send_ticket(pool_ticket(2, 8'd255, 32'd100061));

    clock_now = $urandom;
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      write_window(windows[p]);
      run_random(126);
    end

    wait_drained();
    repeat (300) @(posedge clk);
    if (verdicts.bad == 0 && verdicts.due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/trc_pkg.sv
rtl/trc_ifs.sv
rtl/trc_entry_ram.sv
rtl/trc_hour_div.sv
rtl/ticket_replay_cache_unit.sv
rtl/trc_checker.sv
dv/ticket_replay_cache_unit_tb.sv
